FILE: sv/mmtrc_pkg.sv
package mmtrc_pkg;

   localparam int MOTORS = 3;
   localparam int IDX_W  = (MOTORS > 1) ? $clog2(MOTORS) : 1;
   localparam int CNT_W  = $clog2(MOTORS + 1) + 1;

   localparam logic [15:0] ELAPSED_MAX       = 16'hFFFF;
   localparam logic [15:0] RUN_TIMEOUT_RESET = 16'd150;
   localparam logic [1:0]  MOTOR_COUNT_RESET = 2'd1;

   localparam logic REG_RUN_TIMEOUT = 1'b0;
   localparam logic REG_MOTOR_COUNT = 1'b1;

   localparam logic [1:0] POS_STOP    = 2'd0;
   localparam logic [1:0] POS_FWD     = 2'd1;
   localparam logic [1:0] POS_BACK    = 2'd2;
   localparam logic [1:0] POS_INVALID = 2'd3;

   localparam logic KIND_DRIVE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [1:0] {
      PH_HALT    = 2'd0,
      PH_RESTART = 2'd1,
      PH_RUN     = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      FN_PASS    = 3'd0,
      FN_SET     = 3'd1,
      FN_TOGGLE  = 3'd2,
      FN_QUERY   = 3'd3,
      FN_RESTART = 3'd4,
      FN_TICK    = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC
   } seq_state_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  setting;
      logic [15:0] elapsed;
   } motor_entry_type;

   typedef struct packed {
      logic            rd_en;
      logic [IDX_W-1:0] rd_idx;
      logic            wr_en;
      logic [IDX_W-1:0] wr_idx;
      motor_entry_type wr_data;
   } mem_req_type;

endpackage

FILE: sv/multi_motor_timed_run_controller_unit.sv
// channel   dir   handshake                  payload
// req_      in    req_tvalid / req_tready    tuser func, tdata motor_id, position
// rsp_      out   rsp_tvalid / rsp_tready    tuser kind, tdata id/drive/target, tlast
// csr_      in    APB, pready tied high      run_timeout @0x0, motor_count @0x4
//
// One item at a time. Each motor visit is a read state and a modify/write state on the
// state store. Pass and restart visit each active motor, tick visits all MOTORS,
// set/toggle/query visit one. Items with no visit (unknown func, pass or restart with no
// active motor) are taken without leaving idle.
// A full output register stalls the visit that emits a beat. Reset is synchronous.
module multi_motor_timed_run_controller_unit
   import mmtrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [2:0] motor_id, [4:3] position, [7:5] zero
   input  logic [2:0]  req_tuser,   // [2:0] func

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [2:0] motor_out_id, [4:3] drive, [5] drive_valid,
                                    // [7:6] target
   output logic [0:0]  rsp_tuser,   // [0] kind
   output logic        rsp_tlast,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // configuration
   logic [15:0] run_timeout_ff, run_timeout_in;
   logic [1:0]  motor_count_ff, motor_count_in;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      run_timeout_in = run_timeout_ff;
      motor_count_in = motor_count_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_RUN_TIMEOUT: run_timeout_in = csr_pwdata[15:0];
            REG_MOTOR_COUNT: motor_count_in = csr_pwdata[1:0];
            default:         run_timeout_in = run_timeout_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_RUN_TIMEOUT: csr_prdata = {16'd0, run_timeout_ff};
         REG_MOTOR_COUNT: csr_prdata = {30'd0, motor_count_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_timeout_ff <= RUN_TIMEOUT_RESET;
         motor_count_ff <= MOTOR_COUNT_RESET;
      end else begin
         run_timeout_ff <= run_timeout_in;
         motor_count_ff <= motor_count_in;
      end
   end

   // sequencer
   seq_state_type    state_ff, state_in;
   func_type         func_ff, func_in;
   logic [2:0]       id_ff, id_in;
   logic [1:0]       pos_ff, pos_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] last_idx_ff, last_idx_in;

   logic [CNT_W-1:0] n_active;
   logic [CNT_W-1:0] visits;
   logic             req_beat;
   logic             hit;
   logic             is_last;
   logic             exec_go;
   logic             out_busy;

   motor_entry_type  rd_entry;
   motor_entry_type  new_entry;
   mem_req_type      mem_req;
   logic             wr_need;
   logic             emit;
   logic             beat_kind;
   logic [1:0]       beat_drive;
   logic             beat_dvalid;
   logic [1:0]       beat_target;
   logic [2:0]       beat_id;
   logic             beat_last;

   assign n_active = (CNT_W'(motor_count_ff) > CNT_W'(MOTORS)) ?
                     CNT_W'(MOTORS) : CNT_W'(motor_count_ff);
   assign hit      = CNT_W'(req_tdata[2:0]) < n_active;
   assign req_beat = req_tvalid & req_tready;
   assign is_last  = idx_ff == last_idx_ff;
   assign out_busy = rsp_tvalid & ~rsp_tready;
   assign exec_go  = (state_ff == ST_EXEC) && !(emit && out_busy);

   always_comb begin
      case (func_type'(req_tuser)) inside
         FN_PASS, FN_RESTART:         visits = n_active;
         FN_TICK:                     visits = CNT_W'(MOTORS);
         FN_SET, FN_TOGGLE, FN_QUERY: visits = CNT_W'(1);
         default:                     visits = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_beat && visits != '0) state_in = ST_READ;
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: if (exec_go) state_in = is_last ? ST_IDLE : ST_READ;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      func_in     = func_ff;
      id_in       = id_ff;
      pos_in      = pos_ff;
      hit_in      = hit_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      if (req_beat) begin
         func_in     = func_type'(req_tuser);
         id_in       = req_tdata[2:0];
         pos_in      = req_tdata[4:3];
         hit_in      = hit;
         // single-motor items start and end on the addressed entry, or entry 0 on a miss
         case (func_type'(req_tuser)) inside
            FN_SET, FN_TOGGLE, FN_QUERY: begin
               idx_in      = hit ? req_tdata[IDX_W-1:0] : '0;
               last_idx_in = hit ? req_tdata[IDX_W-1:0] : '0;
            end
            default: begin
               idx_in      = '0;
               last_idx_in = IDX_W'(visits - CNT_W'(1));
            end
         endcase
      end else if (exec_go && !is_last) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      id_ff       <= id_in;
      pos_ff      <= pos_in;
      hit_ff      <= hit_in;
      idx_ff      <= idx_in;
      last_idx_ff <= last_idx_in;
   end

   assign req_tready = state_ff == ST_IDLE;

   // per-motor modify step on the entry read in the ST_READ state
   always_comb begin
      new_entry   = rd_entry;
      wr_need     = 1'b0;
      emit        = 1'b0;
      beat_kind   = KIND_DRIVE;
      beat_drive  = POS_STOP;
      beat_dvalid = 1'b0;
      beat_target = POS_STOP;
      beat_id     = 3'(idx_ff);
      beat_last   = is_last;
      case (func_ff)
         FN_PASS: begin
            wr_need = 1'b1;
            emit    = 1'b1;
            case (rd_entry.phase)
               PH_RESTART: begin
                  new_entry.elapsed = '0;
                  new_entry.phase   = PH_RUN;
               end
               PH_RUN: begin
                  if (rd_entry.elapsed >= run_timeout_ff || rd_entry.setting == POS_STOP) begin
                     new_entry.phase = PH_HALT;
                  end else begin
                     beat_drive  = (rd_entry.setting == POS_FWD) ? POS_FWD : POS_BACK;
                     beat_dvalid = 1'b1;
                  end
               end
               default: beat_dvalid = 1'b1;
            endcase
         end
         FN_SET: begin
            if (hit_ff && pos_ff != POS_INVALID) begin
               wr_need = 1'b1;
               if (pos_ff != rd_entry.setting) new_entry.phase = PH_RESTART;
               new_entry.setting = pos_ff;
            end
         end
         FN_TOGGLE: begin
            if (hit_ff) begin
               wr_need           = 1'b1;
               new_entry.setting = (rd_entry.setting == POS_BACK) ? POS_FWD : POS_BACK;
               new_entry.phase   = PH_RESTART;
            end
         end
         FN_QUERY: begin
            emit        = 1'b1;
            beat_kind   = KIND_QUERY;
            beat_id     = id_ff;
            beat_target = hit_ff ? rd_entry.setting : POS_INVALID;
            beat_last   = 1'b1;
         end
         FN_RESTART: begin
            wr_need         = 1'b1;
            new_entry.phase = PH_RESTART;
         end
         FN_TICK: begin
            wr_need = 1'b1;
            if (rd_entry.elapsed != ELAPSED_MAX) new_entry.elapsed = rd_entry.elapsed + 16'd1;
         end
         default: wr_need = 1'b0;
      endcase
   end

   always_comb begin
      mem_req.rd_en   = state_ff == ST_READ;
      mem_req.rd_idx  = idx_ff;
      mem_req.wr_en   = exec_go && wr_need;
      mem_req.wr_idx  = idx_ff;
      mem_req.wr_data = new_entry;
   end

   mmtrc_state_mem u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .req     (mem_req),
      .rd_data (rd_entry)
   );

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff;
   logic       rsp_kind_ff;
   logic       rsp_last_ff;
   logic       rsp_load;

   assign rsp_load = exec_go && emit;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {beat_target, beat_dvalid, beat_drive, beat_id};
         rsp_kind_ff <= beat_kind;
         rsp_last_ff <= beat_last;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_kind_ff;
   assign rsp_tlast    = rsp_last_ff;

endmodule

FILE: sv/mmtrc_state_mem.sv
module mmtrc_state_mem
   import mmtrc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  mem_req_type     req,
   output motor_entry_type rd_data
);

   motor_entry_type store_ff [MOTORS];
   logic [MOTORS-1:0] valid_ff;
   logic [MOTORS-1:0] valid_in;
   motor_entry_type   rd_data_ff;
   logic              rd_valid_ff;

   // entries not written since reset read as the reset state (halt, stop, zero)
   always_comb begin
      valid_in = valid_ff;
      if (req.wr_en) begin
         valid_in[req.wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         store_ff[req.wr_idx] <= req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data_ff  <= store_ff[req.rd_idx];
         rd_valid_ff <= valid_ff[req.rd_idx];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

FILE: tb/multi_motor_timed_run_controller_unit_tb.sv
`timescale 1ns / 100ps

module multi_motor_timed_run_controller_unit_tb;
   import mmtrc_pkg::*;

   localparam logic [2:0] FN_SPARE_LO = 3'd6;
   localparam logic [2:0] FN_SPARE_HI = 3'd7;
   localparam int SETTLE_CYCLES = 16;
   localparam int STALL_LIMIT   = 4000;
   localparam int TIMER_TICKS   = 40;

   typedef struct packed {
      logic       kind;
      logic [2:0] id;
      logic [1:0] drive;
      logic       drive_valid;
      logic [1:0] target;
      logic       last;
   } motor_report_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // shadow of the motor table and registers
   phase_type   motor_phase   [MOTORS];
   logic [1:0]  motor_setting [MOTORS];
   logic [15:0] motor_elapsed [MOTORS];
   logic [15:0] timeout_reg;
   logic [1:0]  count_reg;

   motor_report_type motor_reports [$];
   motor_report_type head_report;

   int  errors;
   int  items_sent;
   int  beats_seen;
   int  settings_used;
   int  stall_cycles;
   bit  idle_off;

   multi_motor_timed_run_controller_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_tready <= idle_off || ($urandom_range(99) >= 25);
   end

   task automatic note_field(string name, int want, int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_seen++;
         if (motor_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, actual tuser %0h tdata %0h tlast %0b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
         end else begin
            head_report = motor_reports.pop_front();
            note_field("kind", head_report.kind, rsp_tuser[0]);
            note_field("motor_out_id", head_report.id, rsp_tdata[2:0]);
            note_field("drive", head_report.drive, rsp_tdata[4:3]);
            note_field("drive_valid", head_report.drive_valid, rsp_tdata[5]);
            note_field("target", head_report.target, rsp_tdata[7:6]);
            note_field("last", head_report.last, rsp_tlast);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable) || reset) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // updates the shadow table for one accepted item and queues its reports
   task automatic step_motors(logic [2:0] fn, logic [2:0] id, logic [1:0] pos);
      int n;
      motor_report_type r;
      n = (count_reg > MOTORS) ? MOTORS : count_reg;
      case (fn)
         FN_PASS: begin
            for (int i = 0; i < n; i++) begin
               r = '0;
               r.kind = KIND_DRIVE;
               r.id   = i[2:0];
               if (motor_phase[i] == PH_HALT) begin
                  r.drive_valid = 1'b1;
               end else if (motor_phase[i] == PH_RESTART) begin
                  motor_elapsed[i] = '0;
                  motor_phase[i]   = PH_RUN;
               end else if (motor_elapsed[i] >= timeout_reg ||
                            motor_setting[i] == POS_STOP) begin
                  motor_phase[i] = PH_HALT;
               end else begin
                  r.drive = (motor_setting[i] == POS_FWD) ? POS_FWD : POS_BACK;
                  r.drive_valid = 1'b1;
               end
               r.last = (i == n - 1);
               motor_reports.push_back(r);
            end
         end
         FN_SET: begin
            if (id < n && pos != POS_INVALID) begin
               if (pos != motor_setting[id]) motor_phase[id] = PH_RESTART;
               motor_setting[id] = pos;
            end
         end
         FN_TOGGLE: begin
            if (id < n) begin
               motor_setting[id] = (motor_setting[id] == POS_BACK) ? POS_FWD : POS_BACK;
               motor_phase[id]   = PH_RESTART;
            end
         end
         FN_QUERY: begin
            r = '0;
            r.kind   = KIND_QUERY;
            r.id     = id;
            r.target = (id < n) ? motor_setting[id] : POS_INVALID;
            r.last   = 1'b1;
            motor_reports.push_back(r);
         end
         FN_RESTART: begin
            for (int i = 0; i < n; i++) motor_phase[i] = PH_RESTART;
         end
         FN_TICK: begin
            for (int i = 0; i < MOTORS; i++)
               if (motor_elapsed[i] != ELAPSED_MAX) motor_elapsed[i]++;
         end
         default: ;
      endcase
   endtask

   // called on a rising edge; returns on the edge that accepts the beat
   task automatic send_item(logic [2:0] fn, logic [2:0] id, logic [1:0] pos);
      if (!idle_off && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, pos, id};
      req_tuser  <= fn;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      step_motors(fn, id, pos);
   endtask

   // drop valid and let the block drain, including items with no result
   task automatic settle_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (motor_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] val);
      settle_block();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_RUN_TIMEOUT) timeout_reg = val[15:0];
      else count_reg = val[1:0];
      settings_used++;
   endtask

   task automatic test_after_reset();
      send_item(FN_QUERY, 3'd0, POS_STOP);
      send_item(FN_QUERY, 3'd1, POS_STOP);
      send_item(FN_QUERY, 3'd7, POS_INVALID);
      send_item(FN_PASS, 3'd0, POS_STOP);
   endtask

   task automatic test_special_cases();
      write_reg(REG_MOTOR_COUNT, 32'd3);
      write_reg(REG_RUN_TIMEOUT, 32'd0);
      send_item(FN_SET, 3'd0, POS_FWD);
      send_item(FN_SET, 3'd1, POS_BACK);
      send_item(FN_SET, 3'd2, POS_INVALID);   // ignored
      send_item(FN_SET, 3'd0, POS_FWD);       // same target, phase kept
      send_item(FN_TOGGLE, 3'd2, POS_STOP);   // stop -> backward
      send_item(FN_TOGGLE, 3'd1, POS_STOP);   // backward -> forward
      send_item(FN_QUERY, 3'd2, POS_STOP);
      send_item(FN_PASS, 3'd0, POS_STOP);     // restart -> run
      send_item(FN_PASS, 3'd0, POS_STOP);     // zero timeout halts
      send_item(FN_PASS, 3'd0, POS_STOP);
      send_item(FN_SPARE_LO, 3'd7, POS_INVALID);
      send_item(FN_SPARE_HI, 3'd1, POS_FWD);
      send_item(FN_RESTART, 3'd0, POS_STOP);
      write_reg(REG_RUN_TIMEOUT, 32'hFFFF);
      send_item(FN_PASS, 3'd0, POS_STOP);
      send_item(FN_PASS, 3'd0, POS_STOP);     // running, drives direction
      send_item(FN_SET, 3'd0, POS_STOP);
      send_item(FN_TICK, 3'd0, POS_STOP);
      send_item(FN_PASS, 3'd0, POS_STOP);
      send_item(FN_PASS, 3'd0, POS_STOP);     // stop target halts
   endtask

   task automatic test_count_zero();
      write_reg(REG_MOTOR_COUNT, 32'd0);
      send_item(FN_PASS, 3'd0, POS_STOP);
      send_item(FN_QUERY, 3'd0, POS_STOP);
      send_item(FN_SET, 3'd1, POS_FWD);
      send_item(FN_TOGGLE, 3'd2, POS_STOP);
      send_item(FN_RESTART, 3'd0, POS_STOP);
      write_reg(REG_MOTOR_COUNT, 32'd3);
      send_item(FN_QUERY, 3'd1, POS_STOP);
      send_item(FN_PASS, 3'd0, POS_STOP);
   endtask

   task automatic test_timer_timeout();
      write_reg(REG_RUN_TIMEOUT, 32'd30);
      write_reg(REG_MOTOR_COUNT, 32'd3);
      send_item(FN_SET, 3'd0, POS_FWD);
      send_item(FN_SET, 3'd1, POS_BACK);
      send_item(FN_SET, 3'd2, POS_FWD);
      send_item(FN_RESTART, 3'd0, POS_STOP);
      send_item(FN_PASS, 3'd0, POS_STOP);
      send_item(FN_PASS, 3'd0, POS_STOP);
      idle_off = 1'b1;
      // timers run past the limit, so the next passes halt the motors
      repeat (TIMER_TICKS) send_item(FN_TICK, 3'd0, POS_STOP);
      idle_off = 1'b0;
      send_item(FN_PASS, 3'd0, POS_STOP);
      send_item(FN_PASS, 3'd0, POS_STOP);
   endtask

   task automatic test_random_traffic(logic [15:0] tmo, logic [1:0] cnt, int n_items,
                                      bit calm_start, bit mid_pause);
      int r;
      logic [2:0] fn;
      logic [2:0] id;
      logic [1:0] pos;
      write_reg(REG_RUN_TIMEOUT, {16'd0, tmo});
      write_reg(REG_MOTOR_COUNT, {30'd0, cnt});
      idle_off = calm_start;
      for (int k = 0; k < n_items; k++) begin
         if (k == 30) idle_off = 1'b0;
         // with mid_pause, the sender holds off halfway until the block has answered everything
         if (mid_pause && k == n_items / 2) settle_block();
         r = $urandom_range(99);
         if (r < 25)      fn = FN_PASS;
         else if (r < 55) fn = FN_TICK;
         else if (r < 68) fn = FN_SET;
         else if (r < 76) fn = FN_TOGGLE;
         else if (r < 86) fn = FN_QUERY;
         else if (r < 92) fn = FN_RESTART;
         else if (r < 95) fn = ($urandom_range(1) != 0) ? FN_SPARE_HI : FN_SPARE_LO;
         else             fn = 3'($urandom_range(7));
         id  = ($urandom_range(99) < 80) ? 3'($urandom_range(2)) : 3'($urandom_range(7));
         pos = ($urandom_range(99) < 90) ? 2'($urandom_range(2)) : POS_INVALID;
         send_item(fn, id, pos);
      end
      idle_off = 1'b0;
   endtask

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      errors        = 0;
      items_sent    = 0;
      beats_seen    = 0;
      settings_used = 0;
      idle_off      = 1'b0;
      for (int i = 0; i < MOTORS; i++) begin
         motor_phase[i]   = PH_HALT;
         motor_setting[i] = POS_STOP;
         motor_elapsed[i] = '0;
      end
      timeout_reg = RUN_TIMEOUT_RESET;
      count_reg   = MOTOR_COUNT_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_after_reset();
      test_special_cases();
      test_count_zero();
      test_timer_timeout();
      test_random_traffic(16'd3, 2'd3, 65, 1'b1, 1'b0);
      test_random_traffic(16'd1, 2'd2, 65, 1'b0, 1'b1);
      test_random_traffic(16'd0, 2'd3, 65, 1'b0, 1'b0);
      test_random_traffic(16'd150, 2'd1, 65, 1'b0, 1'b0);
      test_random_traffic(16'hFFFF, 2'd3, 65, 1'b0, 1'b0);
      test_random_traffic(16'($urandom_range(2, 12)), 2'd3, 65, 1'b0, 1'b1);

      settle_block();
      $display("Covered reset state, every func incl. spare codes, count 0..3, timeouts 0..65535");
      $display("and timer timeout: %0d items, %0d register writes, %0d result beats",
               items_sent, settings_used, beats_seen);
      if (errors == 0 && motor_reports.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         if (motor_reports.size() != 0)
            $display("%0t: %0d results never arrived", $time, motor_reports.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: multi_motor_timed_run_controller_unit.f
sv/mmtrc_pkg.sv
sv/mmtrc_state_mem.sv
sv/multi_motor_timed_run_controller_unit.sv
tb/multi_motor_timed_run_controller_unit_tb.sv
